[rtl/pidpwm_pkg.sv]
// ----------------------------------------------------------------------------
// pidpwm_pkg
// shared widths, register indexes and the sequencer program of the pid duty
// controller
// ----------------------------------------------------------------------------
package pidpwm_pkg;

    localparam int ADC_BITS_DEFAULT  = 10;
    localparam int FRAC_BITS_DEFAULT = 16;

    localparam int TARGET_W   = 10;
    localparam int THR_W      = 8;
    localparam int DUTY_W     = 8;
    localparam int PROP_W     = 32;
    localparam int ACC_W      = 40;
    localparam int DTERM_W    = PROP_W + 4;
    localparam int MUL14_W    = PROP_W + 5;
    localparam int SUM_W      = ACC_W + 2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    localparam logic [CFG_IDX_W-1:0] REG_TARGET    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = CFG_IDX_W'(1);

    localparam logic [TARGET_W-1:0] TARGET_RESET = TARGET_W'(80);
    localparam logic [THR_W-1:0]    THR_RESET    = THR_W'(100);
    localparam logic [DUTY_W-1:0]   DUTY_RESET   = DUTY_W'(128);
    localparam logic [DUTY_W-1:0]   DUTY_MAX     = DUTY_W'(255);

    localparam int DIVISOR         = 5;
    localparam int DIV_XW_DEFAULT  = 41;

    localparam int PC_W        = 3;
    localparam int UCODE_DEPTH = 8;

    typedef enum logic [2:0] {
        ACT_START_P = 3'd0,
        ACT_TAKE_P  = 3'd1,
        ACT_START_I = 3'd2,
        ACT_TAKE_I  = 3'd3,
        ACT_START_D = 3'd4,
        ACT_TAKE_D  = 3'd5,
        ACT_SUM     = 3'd6,
        ACT_DUTY    = 3'd7
    } act_t;

    typedef enum logic [1:0] {
        HOLD_NONE  = 2'd0,
        HOLD_INPUT = 2'd1,
        HOLD_DIV   = 2'd2,
        HOLD_OUT   = 2'd3
    } hold_t;

    typedef struct packed {
        act_t            act;
        hold_t           hold;
        logic            jump;
        logic [PC_W-1:0] target;
    } uword_t;

    localparam uword_t UCODE [UCODE_DEPTH] = '{
        '{ACT_START_P, HOLD_INPUT, 1'b0, PC_W'(0)},
        '{ACT_TAKE_P,  HOLD_DIV,   1'b0, PC_W'(0)},
        '{ACT_START_I, HOLD_NONE,  1'b0, PC_W'(0)},
        '{ACT_TAKE_I,  HOLD_DIV,   1'b0, PC_W'(0)},
        '{ACT_START_D, HOLD_NONE,  1'b0, PC_W'(0)},
        '{ACT_TAKE_D,  HOLD_DIV,   1'b0, PC_W'(0)},
        '{ACT_SUM,     HOLD_NONE,  1'b0, PC_W'(0)},
        '{ACT_DUTY,    HOLD_OUT,   1'b1, PC_W'(0)}
    };

endpackage

[rtl/pidpwm_div5.sv]
// ----------------------------------------------------------------------------
// pidpwm_div5
// signed divide by five, truncating toward zero, by a reciprocal shift and
// add series with a final remainder correction
// ----------------------------------------------------------------------------
module pidpwm_div5 #(
    parameter int XW = pidpwm_pkg::DIV_XW_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [XW-1:0] dividend,
    output logic                 done,
    output logic signed [XW-1:0] quotient
);

    localparam int RW = 6;

    localparam logic [2:0] STEP_ADD4  = 3'd0;
    localparam logic [2:0] STEP_ADD8  = 3'd1;
    localparam logic [2:0] STEP_ADD16 = 3'd2;
    localparam logic [2:0] STEP_ADD32 = 3'd3;
    localparam logic [2:0] STEP_REM   = 3'd4;
    localparam logic [2:0] STEP_FIX   = 3'd5;

    logic [XW-1:0] mag_reg;
    logic [XW-1:0] q_reg;
    logic [XW-1:0] q_next;
    logic [RW-1:0] rem_reg;
    logic [RW-1:0] rem_next;
    logic          neg_reg;
    logic [2:0]    cnt_reg;
    logic          busy_reg;
    logic          done_reg;

    logic [XW-1:0]   dv;
    logic [XW-1:0]   mag_in;
    logic [XW-1:0]   q_seed;
    logic [XW-1:0]   five_q;
    logic [RW+3:0]   rem13;

    assign dv     = dividend;
    assign mag_in = dv[XW-1] ? (~dv + XW'(1)) : dv;
    assign q_seed = (mag_in >> 3) + (mag_in >> 4);
    assign five_q = (q_reg << 2) + q_reg;
    assign rem13  = (RW + 4)'({rem_reg, 3'b000}) + (RW + 4)'({rem_reg, 2'b00})
                  + (RW + 4)'(rem_reg);

    // q approaches n/5 from below, the remainder fixes the last few units
    always_comb
    begin
        q_next   = q_reg;
        rem_next = rem_reg;
        unique case (cnt_reg)
            STEP_ADD4:  q_next = q_reg + (q_reg >> 4);
            STEP_ADD8:  q_next = q_reg + (q_reg >> 8);
            STEP_ADD16: q_next = q_reg + (q_reg >> 16);
            STEP_ADD32: q_next = q_reg + (q_reg >> 32);
            STEP_REM:   rem_next = RW'(mag_reg - five_q);
            STEP_FIX:   q_next = q_reg + XW'(rem13[RW+3:6]);
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 3'd1;
            if (cnt_reg == STEP_FIX)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mag_reg <= mag_in;
            q_reg   <= q_seed;
            rem_reg <= '0;
            neg_reg <= dv[XW-1];
        end
        else if (busy_reg)
        begin
            q_reg   <= q_next;
            rem_reg <= rem_next;
        end
    end

    assign quotient = neg_reg ? signed'(~q_reg + XW'(1)) : signed'(q_reg);
    assign done     = done_reg;

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider started while busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !done_reg)
        else $error("divider done while busy");

    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && !start) |=> done_reg)
        else $error("divider done dropped without a new start");

endmodule

[rtl/pid_pwm_with_relay_hysteresis.sv]
// ----------------------------------------------------------------------------
// pid_pwm_with_relay_hysteresis
// incremental pid duty controller with a hysteresis relay, run by a small
// microcoded sequencer over one shared divide-by-five unit
// ----------------------------------------------------------------------------
// a new sample is taken only at the start of the program, after three six-step
// passes through the divide-by-five unit; a stalled result holds the program
// reset: duty 128, integral and last proportional zero, relay on,
// target 80, threshold 100; no clearing pass
module pid_pwm_with_relay_hysteresis #(
    parameter int ADC_BITS  = pidpwm_pkg::ADC_BITS_DEFAULT,
    parameter int FRAC_BITS = pidpwm_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [ADC_BITS-1:0]                  sample,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [pidpwm_pkg::DUTY_W-1:0]        pwm_duty,
    output logic                                 relay_on,
    output logic                                 relay_changed,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [pidpwm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pidpwm_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int PW  = pidpwm_pkg::PROP_W;
    localparam int AW  = pidpwm_pkg::ACC_W;
    localparam int DDW = pidpwm_pkg::DTERM_W;
    localparam int M14 = pidpwm_pkg::MUL14_W;
    localparam int SW  = pidpwm_pkg::SUM_W;
    localparam int UW  = pidpwm_pkg::DUTY_W;
    localparam int TW  = (ADC_BITS > pidpwm_pkg::TARGET_W) ? ADC_BITS
                                                           : pidpwm_pkg::TARGET_W;
    localparam int DW  = TW + 1;
    localparam int XW  = (DW + FRAC_BITS > M14) ? DW + FRAC_BITS : M14;

    localparam logic [TW-1:0] ADC_MASK = TW'((64'd1 << ADC_BITS) - 64'd1);
    localparam logic [SW-1:0] RND_BIAS = SW'((64'd1 << FRAC_BITS) - 64'd1);

    // sequencer
    logic [pidpwm_pkg::PC_W-1:0] pc_reg;
    logic [pidpwm_pkg::PC_W-1:0] pc_next;
    pidpwm_pkg::uword_t          uw;
    logic                        holding;
    logic                        advance;

    // configuration and controller state
    logic [pidpwm_pkg::TARGET_W-1:0] target_reg;
    logic [pidpwm_pkg::THR_W-1:0]    thr_reg;
    logic [UW-1:0]                   duty_reg;
    logic signed [AW-1:0]            integ_reg;
    logic signed [PW-1:0]            last_reg;
    logic                            relay_reg;

    // datapath
    logic signed [PW-1:0]  p_reg;
    logic signed [DDW-1:0] d_reg;
    logic signed [SW-1:0]  sum_reg;

    // output register
    logic          out_valid_reg;
    logic [UW-1:0] duty_out_reg;
    logic          relay_out_reg;
    logic          changed_out_reg;

    logic                 div_start;
    logic                 div_done;
    logic signed [XW-1:0] div_dividend;
    logic signed [XW-1:0] q;

    logic [TW-1:0]        s_ext;
    logic [TW-1:0]        t_ext;
    logic signed [DW-1:0] err;
    logic signed [XW-1:0] x_p;
    logic signed [XW-1:0] x_i;
    logic signed [PW:0]   pdiff;
    logic signed [M14-1:0] m14;
    logic signed [XW-1:0] x_d;

    logic signed [PW-1:0] p_sat;
    logic signed [AW:0]   isum;
    logic signed [AW-1:0] i_sat;
    logic signed [SW-1:0] sum_adj;
    logic signed [SW-1:0] u_val;
    logic signed [SW:0]   dtmp;
    logic [UW-1:0]        duty_new;
    logic                 turn_on;
    logic                 turn_off;
    logic                 relay_new;

    logic in_fire;
    logic out_fire;

    assign uw       = pidpwm_pkg::UCODE[pc_reg];
    assign in_stall = (uw.hold != pidpwm_pkg::HOLD_INPUT);
    assign in_fire  = in_valid && !in_stall;
    assign out_fire = out_valid_reg && !out_stall;

    always_comb
    begin
        unique case (uw.hold)
            pidpwm_pkg::HOLD_NONE:  holding = 1'b0;
            pidpwm_pkg::HOLD_INPUT: holding = !in_fire;
            pidpwm_pkg::HOLD_DIV:   holding = !div_done;
            pidpwm_pkg::HOLD_OUT:   holding = out_valid_reg && out_stall;
            default:                holding = 1'b1;
        endcase
    end

    assign advance = !holding;
    assign pc_next = uw.jump ? uw.target : pc_reg + pidpwm_pkg::PC_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= '0;
        end
        else if (advance)
        begin
            pc_reg <= pc_next;
        end
    end

    // operand forming
    assign s_ext = TW'(sample);
    assign t_ext = TW'(target_reg) & ADC_MASK;
    assign err   = signed'({1'b0, s_ext}) - signed'({1'b0, t_ext});
    assign x_p   = XW'(err) <<< FRAC_BITS;
    assign x_i   = XW'(signed'({p_reg, 1'b0}));
    assign pdiff = (PW + 1)'(p_reg) - (PW + 1)'(last_reg);
    assign m14   = (M14'(pdiff) <<< 4) - (M14'(pdiff) <<< 1);
    assign x_d   = XW'(m14);

    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = x_p;
        unique case (uw.act)
            pidpwm_pkg::ACT_START_P:
            begin
                div_start    = advance;
                div_dividend = x_p;
            end
            pidpwm_pkg::ACT_START_I:
            begin
                div_start    = advance;
                div_dividend = x_i;
            end
            pidpwm_pkg::ACT_START_D:
            begin
                div_start    = advance;
                div_dividend = x_d;
            end
            default:
            begin
                div_start    = 1'b0;
                div_dividend = x_p;
            end
        endcase
    end

    pidpwm_div5 #(
        .XW (XW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .done     (div_done),
        .quotient (q)
    );

    // saturation of the proportional and integral terms
    always_comb
    begin
        if (&q[XW-1:PW-1] || ~|q[XW-1:PW-1])
        begin
            p_sat = q[PW-1:0];
        end
        else
        begin
            p_sat = q[XW-1] ? signed'({1'b1, {(PW-1){1'b0}}})
                            : signed'({1'b0, {(PW-1){1'b1}}});
        end
    end

    assign isum = (AW + 1)'(integ_reg) + (AW + 1)'(signed'(q[PW-1:0]));

    always_comb
    begin
        if (isum[AW] == isum[AW-1])
        begin
            i_sat = isum[AW-1:0];
        end
        else
        begin
            i_sat = isum[AW] ? signed'({1'b1, {(AW-1){1'b0}}})
                             : signed'({1'b0, {(AW-1){1'b1}}});
        end
    end

    // duty update, truncating the sum toward zero
    assign sum_adj = sum_reg + (sum_reg[SW-1] ? signed'(RND_BIAS) : signed'(SW'(0)));
    assign u_val   = sum_adj >>> FRAC_BITS;
    assign dtmp    = (SW + 1)'(signed'({1'b0, duty_reg})) - (SW + 1)'(u_val);

    always_comb
    begin
        if (dtmp[SW])
        begin
            duty_new = '0;
        end
        else if (|dtmp[SW-1:UW])
        begin
            duty_new = pidpwm_pkg::DUTY_MAX;
        end
        else
        begin
            duty_new = dtmp[UW-1:0];
        end
    end

    assign turn_on   = ({1'b0, duty_new} + (UW + 1)'(1)) < {1'b0, thr_reg};
    assign turn_off  = duty_new > thr_reg;
    assign relay_new = turn_on ? 1'b1 : (turn_off ? 1'b0 : relay_reg);

    // controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            duty_reg  <= pidpwm_pkg::DUTY_RESET;
            integ_reg <= '0;
            last_reg  <= '0;
            relay_reg <= 1'b1;
        end
        else if (advance)
        begin
            case (uw.act)
                pidpwm_pkg::ACT_TAKE_I:
                begin
                    integ_reg <= i_sat;
                end
                pidpwm_pkg::ACT_TAKE_D:
                begin
                    last_reg <= p_reg;
                end
                pidpwm_pkg::ACT_DUTY:
                begin
                    duty_reg  <= duty_new;
                    relay_reg <= relay_new;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            case (uw.act)
                pidpwm_pkg::ACT_TAKE_P:
                begin
                    p_reg <= p_sat;
                end
                pidpwm_pkg::ACT_TAKE_D:
                begin
                    d_reg <= q[DDW-1:0];
                end
                pidpwm_pkg::ACT_SUM:
                begin
                    sum_reg <= SW'(p_reg) + SW'(integ_reg) + SW'(d_reg);
                end
                pidpwm_pkg::ACT_DUTY:
                begin
                    duty_out_reg    <= duty_new;
                    relay_out_reg   <= relay_new;
                    changed_out_reg <= relay_new != relay_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && uw.act == pidpwm_pkg::ACT_DUTY)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_fire)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= pidpwm_pkg::TARGET_RESET;
            thr_reg    <= pidpwm_pkg::THR_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                pidpwm_pkg::REG_TARGET:
                    target_reg <= cfg_data[pidpwm_pkg::TARGET_W-1:0];
                pidpwm_pkg::REG_THRESHOLD:
                    thr_reg <= cfg_data[pidpwm_pkg::THR_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign pwm_duty      = duty_out_reg;
    assign relay_on      = relay_out_reg;
    assign relay_changed = changed_out_reg;

    a_changed_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && uw.act == pidpwm_pkg::ACT_DUTY)
        |=> changed_out_reg == (relay_reg != $past(relay_reg)))
        else $error("relay change flag disagrees with relay state");

    a_last_prop: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(last_reg) |-> $past(advance && uw.act == pidpwm_pkg::ACT_TAKE_D))
        else $error("last proportional term changed outside its step");

    a_result_end: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> pc_reg == '0)
        else $error("result raised before the program wrapped");

endmodule

[sim/pid_pwm_with_relay_hysteresis_test.sv]
// ----------------------------------------------------------------------------
// pid_pwm_with_relay_hysteresis_test
// drives adc samples and register writes into the pid duty controller and
// checks every duty, relay and relay-change result against an in-bench
// fixed-point model of the controller; covers reset values, setpoint and
// threshold extremes, a zero threshold, spare register indexes, random
// phases with idle bursts on both sides and a full-scale run at the end
// ----------------------------------------------------------------------------
module pid_pwm_with_relay_hysteresis_test;

    localparam int ADC_BITS_DEFAULT  = pidpwm_pkg::ADC_BITS_DEFAULT;
    localparam int FRAC_BITS_DEFAULT = pidpwm_pkg::FRAC_BITS_DEFAULT;
    localparam int TARGET_W          = pidpwm_pkg::TARGET_W;
    localparam int THR_W             = pidpwm_pkg::THR_W;
    localparam int DUTY_W            = pidpwm_pkg::DUTY_W;
    localparam int PROP_W            = pidpwm_pkg::PROP_W;
    localparam int ACC_W             = pidpwm_pkg::ACC_W;
    localparam int CFG_IDX_W         = pidpwm_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W        = pidpwm_pkg::CFG_DATA_W;
    localparam int DIVISOR           = pidpwm_pkg::DIVISOR;

    localparam logic [CFG_IDX_W-1:0] REG_TARGET    = pidpwm_pkg::REG_TARGET;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = pidpwm_pkg::REG_THRESHOLD;
    localparam logic [TARGET_W-1:0]  TARGET_RESET  = pidpwm_pkg::TARGET_RESET;
    localparam logic [THR_W-1:0]     THR_RESET     = pidpwm_pkg::THR_RESET;
    localparam logic [DUTY_W-1:0]    DUTY_RESET    = pidpwm_pkg::DUTY_RESET;
    localparam logic [DUTY_W-1:0]    DUTY_MAX      = pidpwm_pkg::DUTY_MAX;

    localparam int CYCLE_LIMIT   = 400_000;
    localparam int SETTLE_CYCLES = 32;
    localparam int SAMPLE_MAX    = (1 << ADC_BITS_DEFAULT) - 1;
    localparam int RANDOM_BLOCKS = 8;
    localparam int BLOCK_ITEMS   = 100;
    localparam int WINDUP_ITEMS  = 100;
    localparam int TAIL_ITEMS    = 100;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = CFG_IDX_W'(3);

    localparam longint FRAC_ONE   = longint'(1) << FRAC_BITS_DEFAULT;
    localparam longint PROP_LIMIT = (longint'(1) << (PROP_W - 1)) - 1;
    localparam longint ACC_LIMIT  = (longint'(1) << (ACC_W - 1)) - 1;
    localparam longint DUTY_CEIL  = DUTY_MAX;
    localparam longint I_GAIN_NUM = 2;
    localparam longint D_GAIN_NUM = 14;

    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic              relay;
        logic              toggled;
    } duty_result_t;

    class duty_scoreboard;
        logic [TARGET_W-1:0] target    = TARGET_RESET;
        logic [THR_W-1:0]    threshold = THR_RESET;
        logic [DUTY_W-1:0]   duty      = DUTY_RESET;
        longint              integ     = 0;
        longint              last_prop = 0;
        logic                relay     = 1'b1;
        duty_result_t        pending[$];
        int mismatches = 0;
        int samples    = 0;
        int checked    = 0;
        int writes     = 0;
        int toggles    = 0;
        int clamp_hits = 0;

        function longint clip(longint v, longint lim);
            if (v > lim)
                return lim;
            if (v < -lim - 1)
                return -lim - 1;
            return v;
        endfunction

        function void report(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("%s", msg);
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            writes++;
            if (idx == REG_TARGET)
                target = data[TARGET_W-1:0];
            else if (idx == REG_THRESHOLD)
                threshold = data[THR_W-1:0];
        endfunction

        function void note_sample(logic [ADC_BITS_DEFAULT-1:0] smp);
            longint       err;
            longint       setpoint;
            longint       prop;
            longint       raw_integ;
            longint       dterm;
            longint       u;
            longint       next_duty;
            longint       thr;
            logic         prev;
            duty_result_t r;
            prev = relay;
            err = smp;
            setpoint = target;
            err = err - setpoint;
            prop = clip((err * FRAC_ONE) / DIVISOR, PROP_LIMIT);
            raw_integ = integ + (prop * I_GAIN_NUM) / DIVISOR;
            integ = clip(raw_integ, ACC_LIMIT);
            if (integ != raw_integ)
                clamp_hits++;
            dterm = ((prop - last_prop) * D_GAIN_NUM) / DIVISOR;
            last_prop = prop;
            u = (prop + integ + dterm) / FRAC_ONE;
            next_duty = duty;
            next_duty = next_duty - u;
            if (next_duty > DUTY_CEIL)
                next_duty = DUTY_CEIL;
            if (next_duty < 0)
                next_duty = 0;
            duty = next_duty[DUTY_W-1:0];
            thr = threshold;
            if (next_duty < thr - 1)
                relay = 1'b1;
            if (next_duty > thr)
                relay = 1'b0;
            r.duty = duty;
            r.relay = relay;
            r.toggled = (relay != prev);
            if (r.toggled)
                toggles++;
            samples++;
            pending.push_back(r);
        endfunction

        function void check_result(logic [DUTY_W-1:0] d, logic on, logic chg);
            duty_result_t e;
            if (pending.size() == 0)
            begin
                report($sformatf("unexpected result: duty %0d relay %0b changed %0b",
                                 d, on, chg));
                return;
            end
            e = pending.pop_front();
            checked++;
            if (e.duty !== d || e.relay !== on || e.toggled !== chg)
                report($sformatf({"result %0d mismatch: expected duty %0d relay %0b ",
                                  "changed %0b, got duty %0d relay %0b changed %0b"},
                                 checked, e.duty, e.relay, e.toggled, d, on, chg));
        endfunction
    endclass

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_stall;
    logic [ADC_BITS_DEFAULT-1:0] sample;
    logic                        out_valid;
    logic                        out_stall;
    logic [DUTY_W-1:0]           pwm_duty;
    logic                        relay_on;
    logic                        relay_changed;
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic [CFG_IDX_W-1:0]        cfg_index;
    logic [CFG_DATA_W-1:0]       cfg_data;

    bit gap_bursts   = 1'b0;
    bit stall_bursts = 1'b0;
    int cycles       = 0;

    duty_scoreboard sb = new();

    pid_pwm_with_relay_hysteresis dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .sample        (sample),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .pwm_duty      (pwm_duty),
        .relay_on      (relay_on),
        .relay_changed (relay_changed),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, sb.pending.size());
            $display("Verification failed");
            $finish;
        end
    end

    // transfer monitors
    always @(posedge clk)
    begin
        if (rst_n && cfg_valid && cfg_ready)
            sb.write_reg(cfg_index, cfg_data);
        if (rst_n && in_valid && !in_stall)
            sb.note_sample(sample);
        if (rst_n && out_valid && !out_stall)
            sb.check_result(pwm_duty, relay_on, relay_changed);
    end

    // receiver stall bursts
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_bursts && $urandom_range(0, 9) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 17)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    function automatic logic [ADC_BITS_DEFAULT-1:0] pick_sample(int center);
        int v;
        case ($urandom_range(0, 9))
            0, 1:    v = $urandom_range(0, SAMPLE_MAX);
            2, 3:    v = center + int'($urandom_range(0, 127)) - 64;
            default: v = center + int'($urandom_range(0, 12)) - 6;
        endcase
        if (v < 0)
            v = 0;
        if (v > SAMPLE_MAX)
            v = SAMPLE_MAX;
        return v[ADC_BITS_DEFAULT-1:0];
    endfunction

    task automatic send_sample(input logic [ADC_BITS_DEFAULT-1:0] value);
        if (gap_bursts && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            sample <= ADC_BITS_DEFAULT'($urandom);
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        in_valid <= 1'b1;
        sample <= value;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic wait_idle();
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic post_register(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] target_data,
                             input logic [CFG_DATA_W-1:0] thr_data);
        in_valid <= 1'b0;
        wait_idle();
        post_register($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3,
                      CFG_DATA_W'($urandom));
        post_register(REG_TARGET, target_data);
        post_register(REG_THRESHOLD, thr_data);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int reset_sweep[10] = '{80, 80, 0, 1023, 1023, 0, 81, 79, 'h2AA, 'h155};
        int low_target[4]   = '{1023, 0, 0, 512};
        int high_target[4]  = '{0, 1023, 1023, 0};
        int zero_thr[6]     = '{600, 700, 512, 400, 300, 100};
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        sample <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_TARGET;
        cfg_data <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        foreach (reset_sweep[i])
            send_sample(ADC_BITS_DEFAULT'(reset_sweep[i]));
        configure(CFG_DATA_W'(0), CFG_DATA_W'(255));
        foreach (low_target[i])
            send_sample(ADC_BITS_DEFAULT'(low_target[i]));
        configure(CFG_DATA_W'(1023), CFG_DATA_W'(1));
        foreach (high_target[i])
            send_sample(ADC_BITS_DEFAULT'(high_target[i]));
        // threshold zero, written with only the upper data bits set
        configure(CFG_DATA_W'(512), CFG_DATA_W'('h300));
        foreach (zero_thr[i])
            send_sample(ADC_BITS_DEFAULT'(zero_thr[i]));

        for (int blk = 0; blk < RANDOM_BLOCKS; blk++)
        begin
            configure(CFG_DATA_W'($urandom_range(0, SAMPLE_MAX)), CFG_DATA_W'($urandom));
            gap_bursts = (blk != 3);
            stall_bursts = (blk != 3);
            repeat (BLOCK_ITEMS)
                send_sample(pick_sample(sb.target));
        end

        // full-scale run driving the integral up, no idling
        configure(CFG_DATA_W'(0), CFG_DATA_W'($urandom));
        gap_bursts = 1'b0;
        stall_bursts = 1'b0;
        repeat (WINDUP_ITEMS)
            send_sample(ADC_BITS_DEFAULT'(SAMPLE_MAX));
        repeat (TAIL_ITEMS)
            send_sample(pick_sample(0));
        in_valid <= 1'b0;
        wait_idle();

        $display("%0d samples sent, %0d duty results checked, %0d register writes",
                 sb.samples, sb.checked, sb.writes);
        $display("relay switched %0d times, integral clamped on %0d samples, %0d mismatches",
                 sb.toggles, sb.clamp_hits, sb.mismatches);
        if (sb.mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
